>>> hdl/sprcp_pkg.sv
// shared widths, register indexes and status codes of the sprite projection unit
package sprcp_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_CAM_X    = 3'd0;
  localparam logic [2:0] REG_CAM_Y    = 3'd1;
  localparam logic [2:0] REG_DIR_X    = 3'd2;
  localparam logic [2:0] REG_DIR_Y    = 3'd3;
  localparam logic [2:0] REG_PLANE_X  = 3'd4;
  localparam logic [2:0] REG_PLANE_Y  = 3'd5;
  localparam logic [2:0] REG_WIDTH    = 3'd6;
  localparam logic [2:0] REG_HEIGHT   = 3'd7;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DEPTH_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SINGULAR = 2'd2;

  // datapath widths
  localparam int unsigned POS_W    = 16;
  localparam int unsigned VEC_W    = 16;
  localparam int unsigned EXT_W    = 13;
  localparam int unsigned DX_W     = 17;
  localparam int unsigned PROD_W   = 33;
  localparam int unsigned DPROD_W  = 32;
  localparam int unsigned NX_W     = 34;
  localparam int unsigned DET_W    = 33;
  localparam int unsigned SUM_W    = 35;
  localparam int unsigned SABS_W   = 34;
  localparam int unsigned NYABS_W  = 33;
  localparam int unsigned DETABS_W = 32;
  localparam int unsigned HW_W     = 12;
  localparam int unsigned M2_W     = 46;
  localparam int unsigned DIV_W    = 55;
  localparam int unsigned D1_W     = 32;
  localparam int unsigned D2_W     = 33;
  localparam int unsigned Q3_W     = 29;
  localparam int unsigned D3_W     = 32;
  localparam int unsigned DEPTH_W  = 32;
  localparam int unsigned COL_W    = 16;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned BND_W    = 18;

  // total cycles from request to result
  localparam int unsigned LATENCY  = 5 + DIV_W + 1 + Q3_W + 2;

  // flags that ride along the first dividers
  typedef struct packed {
    logic v;
    logic dz;
    logic n1;
    logic n2;
  } div_side_t;

  // data that rides along the size divider
  typedef struct packed {
    logic                      v;
    logic                      dz;
    logic                      dzero;
    logic [DEPTH_W-1:0]        depth;
    logic signed [COL_W-1:0]   center;
  } size_side_t;

endpackage

>>> hdl/sprite_camera_projection_unit.sv
// sprite camera projection: camera transform, depth, size and draw bounds
//
//  channel   signals                                  direction  handshake
//  config    cfg_we_i cfg_addr_i cfg_wdata_i          in         write at cfg_we_i
//  request   start_i sprite_pos_x_i sprite_pos_y_i    in         start_i && !busy_o
//  result    done_o status_o depth_o ... end_row_o    out        one-cycle strobe done_o
//
// one request accepted every cycle; busy_o stays low
// each result passes through five setup stages, a 55-stage radix-2 divider pair
// (depth and center), one saturation stage, a 29-stage size divider, a size
// saturation stage and a bound stage
// reset clears the valid bits with the side data riding beside them and loads the
// default camera; operand registers are not reset
// the receiver cannot stall, so the pipeline never holds
module sprite_camera_projection_unit
  import sprcp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_addr_i,
  input  logic [15:0]               cfg_wdata_i,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [POS_W-1:0]          sprite_pos_x_i,
  input  logic [POS_W-1:0]          sprite_pos_y_i,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic signed [DEPTH_W-1:0] depth_o,
  output logic signed [COL_W-1:0]   center_column_o,
  output logic [SIZE_W-1:0]         sprite_size_o,
  output logic [14:0]               start_column_o,
  output logic signed [COL_W-1:0]   end_column_o,
  output logic [14:0]               start_row_o,
  output logic signed [COL_W-1:0]   end_row_o
);

  // configuration registers
  logic [POS_W-1:0]        cam_x_q, cam_y_q;
  logic signed [VEC_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [EXT_W-1:0]        width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q   <= '0;
      cam_y_q   <= '0;
      dir_x_q   <= 16'sd16384;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= 16'sd10813;
      width_q   <= 13'd640;
      height_q  <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_CAM_X:   cam_x_q   <= cfg_wdata_i;
        REG_CAM_Y:   cam_y_q   <= cfg_wdata_i;
        REG_DIR_X:   dir_x_q   <= cfg_wdata_i;
        REG_DIR_Y:   dir_y_q   <= cfg_wdata_i;
        REG_PLANE_X: plane_x_q <= cfg_wdata_i;
        REG_PLANE_Y: plane_y_q <= cfg_wdata_i;
        REG_WIDTH:   width_q   <= cfg_wdata_i[EXT_W-1:0];
        REG_HEIGHT:  height_q  <= cfg_wdata_i[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  // fully pipelined, never busy
  assign busy_o = 1'b0;
  logic accept;
  assign accept = start_i && !busy_o;

  // user must keep config stable while requests are in flight (unchecked); read live
  logic [HW_W-1:0] half_w, half_h;
  assign half_w = width_q[EXT_W-1:1];
  assign half_h = height_q[EXT_W-1:1];

  // ---------------- stage 1: offsets from the camera
  logic                   v1_q;
  logic signed [DX_W-1:0] dx1_q, dy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= accept;
  end
  always_ff @(posedge clk_i) begin
    dx1_q <= $signed({1'b0, sprite_pos_x_i}) - $signed({1'b0, cam_x_q});
    dy1_q <= $signed({1'b0, sprite_pos_y_i}) - $signed({1'b0, cam_y_q});
  end

  // ---------------- stage 2: the six products
  logic                     v2_q;
  logic signed [PROD_W-1:0] p_dyx_q, p_dxy_q, p_pxy_q, p_pyx_q;
  logic signed [DPROD_W-1:0] p_det_a_q, p_det_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    p_dyx_q   <= PROD_W'(dir_y_q) * PROD_W'(dx1_q);
    p_dxy_q   <= PROD_W'(dir_x_q) * PROD_W'(dy1_q);
    p_pxy_q   <= PROD_W'(plane_x_q) * PROD_W'(dy1_q);
    p_pyx_q   <= PROD_W'(plane_y_q) * PROD_W'(dx1_q);
    p_det_a_q <= DPROD_W'(plane_x_q) * DPROD_W'(dir_y_q);
    p_det_b_q <= DPROD_W'(dir_x_q) * DPROD_W'(plane_y_q);
  end

  // ---------------- stage 3: inverse-matrix numerators and determinant
  logic                   v3_q;
  logic signed [NX_W-1:0] nx3_q, ny3_q;
  logic signed [DET_W-1:0] det3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    nx3_q  <= NX_W'(p_dyx_q) - NX_W'(p_dxy_q);
    ny3_q  <= NX_W'(p_pxy_q) - NX_W'(p_pyx_q);
    det3_q <= DET_W'(p_det_a_q) - DET_W'(p_det_b_q);
  end

  // ---------------- stage 4: magnitudes and quotient signs
  logic                v4_q, dz4_q, n1_4_q, n2_4_q;
  logic [SABS_W-1:0]   sabs4_q;
  logic [NYABS_W-1:0]  nyabs4_q;
  logic [DETABS_W-1:0] detabs4_q;
  logic signed [SUM_W-1:0] sum3;
  logic signed [NX_W-1:0]  nyneg3;
  logic signed [DET_W-1:0] detneg3;
  logic signed [SUM_W-1:0] sumneg3;

  assign sum3    = SUM_W'(nx3_q) + SUM_W'(ny3_q);
  assign nyneg3  = -ny3_q;
  assign detneg3 = -det3_q;
  assign sumneg3 = -sum3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    dz4_q     <= (det3_q == '0);
    n1_4_q    <= ny3_q[NX_W-1] ^ det3_q[DET_W-1];
    n2_4_q    <= sum3[SUM_W-1] ^ ny3_q[NX_W-1];
    sabs4_q   <= sum3[SUM_W-1] ? sumneg3[SABS_W-1:0] : sum3[SABS_W-1:0];
    nyabs4_q  <= ny3_q[NX_W-1] ? nyneg3[NYABS_W-1:0] : ny3_q[NYABS_W-1:0];
    detabs4_q <= det3_q[DET_W-1] ? detneg3[DETABS_W-1:0] : det3_q[DETABS_W-1:0];
  end

  // ---------------- stage 5: divider operands
  div_side_t        side5_q;
  logic [DIV_W-1:0] num1_5_q, num2_5_q;
  logic [D1_W-1:0]  den1_5_q;
  logic [D2_W-1:0]  den2_5_q;
  logic [M2_W-1:0]  m2_4;

  assign m2_4 = M2_W'(half_w) * M2_W'(sabs4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) side5_q <= '0;
    else         side5_q <= '{v: v4_q, dz: dz4_q, n1: n1_4_q, n2: n2_4_q};
  end
  always_ff @(posedge clk_i) begin
    num1_5_q   <= {nyabs4_q, 22'd0};
    den1_5_q   <= detabs4_q;
    num2_5_q   <= DIV_W'(m2_4);
    den2_5_q   <= nyabs4_q;
  end

  // ---------------- depth and center dividers: one quotient bit per stage
  // the dividend register shifts left and collects quotient bits at its bottom
  div_side_t        dside_q [DIV_W];
  logic [D1_W-1:0]  r1_q [DIV_W], r1_d [DIV_W], e1_q [DIV_W];
  logic [D2_W-1:0]  r2_q [DIV_W], r2_d [DIV_W], e2_q [DIV_W];
  logic [DIV_W-1:0] n1_q [DIV_W], n1_d [DIV_W];
  logic [DIV_W-1:0] n2_q [DIV_W], n2_d [DIV_W];

  always_comb begin
    logic [D1_W-1:0]  pr1;
    logic [D1_W-1:0]  pd1;
    logic [D1_W:0]    t1;
    logic [D2_W-1:0]  pr2;
    logic [D2_W-1:0]  pd2;
    logic [D2_W:0]    t2;
    logic [DIV_W-1:0] pn1, pn2;
    logic             b1, b2;
    for (int k = 0; k < DIV_W; k++) begin
      if (k == 0) begin
        pr1 = '0; pn1 = num1_5_q; pd1 = den1_5_q;
        pr2 = '0; pn2 = num2_5_q; pd2 = den2_5_q;
      end else begin
        pr1 = r1_q[k-1]; pn1 = n1_q[k-1]; pd1 = e1_q[k-1];
        pr2 = r2_q[k-1]; pn2 = n2_q[k-1]; pd2 = e2_q[k-1];
      end
      t1 = {pr1, pn1[DIV_W-1]};
      b1 = (t1 >= {1'b0, pd1});
      if (b1) t1 = t1 - {1'b0, pd1};
      r1_d[k] = t1[D1_W-1:0];
      n1_d[k] = {pn1[DIV_W-2:0], b1};
      t2 = {pr2, pn2[DIV_W-1]};
      b2 = (t2 >= {1'b0, pd2});
      if (b2) t2 = t2 - {1'b0, pd2};
      r2_d[k] = t2[D2_W-1:0];
      n2_d[k] = {pn2[DIV_W-2:0], b2};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_W; k++) dside_q[k] <= '0;
    end else begin
      dside_q[0] <= side5_q;
      for (int k = 1; k < DIV_W; k++) dside_q[k] <= dside_q[k-1];
    end
  end
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_W; k++) begin
      r1_q[k] <= r1_d[k];
      n1_q[k] <= n1_d[k];
      r2_q[k] <= r2_d[k];
      n2_q[k] <= n2_d[k];
      if (k == 0) begin
        e1_q[k]       <= den1_5_q;
        e2_q[k]       <= den2_5_q;
      end else begin
        e1_q[k]       <= e1_q[k-1];
        e2_q[k]       <= e2_q[k-1];
      end
    end
  end

  // ---------------- stage 6: signed saturation of depth and center
  div_side_t        last;
  logic [DIV_W-1:0] q1, q2;
  size_side_t       sz0_d;
  logic [D3_W-1:0]  dabs0_d;
  logic [DEPTH_W-1:0] q1neg;
  logic [COL_W-1:0]   q2neg;

  assign last  = dside_q[DIV_W-1];
  assign q1    = n1_q[DIV_W-1];
  assign q2    = n2_q[DIV_W-1];
  assign q1neg = -q1[DEPTH_W-1:0];
  assign q2neg = -q2[COL_W-1:0];

  always_comb begin
    sz0_d.v     = last.v;
    sz0_d.dz    = last.dz;
    sz0_d.dzero = (q1 == '0);
    if (last.n1) begin
      // most negative depth allowed is -2^31
      if (q1 > DIV_W'(64'h8000_0000)) begin
        sz0_d.depth = 32'h8000_0000;
        dabs0_d     = 32'h8000_0000;
      end else begin
        sz0_d.depth = q1neg;
        dabs0_d     = q1[D3_W-1:0];
      end
    end else begin
      if (q1 > DIV_W'(64'h7FFF_FFFF)) begin
        sz0_d.depth = 32'h7FFF_FFFF;
        dabs0_d     = 32'h7FFF_FFFF;
      end else begin
        sz0_d.depth = q1[DEPTH_W-1:0];
        dabs0_d     = q1[D3_W-1:0];
      end
    end
    if (last.n2) begin
      sz0_d.center = (q2 > DIV_W'(32768)) ? -16'sd32768 : $signed(q2neg);
    end else begin
      sz0_d.center = (q2 > DIV_W'(32767)) ? 16'sd32767 : $signed(q2[COL_W-1:0]);
    end
  end

  size_side_t       sz6_q;
  logic [D3_W-1:0]  den3_6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sz6_q <= '0;
    else         sz6_q <= sz0_d;
  end
  always_ff @(posedge clk_i) begin
    den3_6_q     <= dabs0_d;
  end

  // ---------------- size divider: height * 2^16 / |depth|
  size_side_t      sside_q [Q3_W];
  logic [D3_W-1:0] r3_q [Q3_W], r3_d [Q3_W], e3_q [Q3_W];
  logic [Q3_W-1:0] n3_q [Q3_W], n3_d [Q3_W];

  always_comb begin
    logic [D3_W-1:0] pr;
    logic [D3_W-1:0] pd;
    logic [D3_W:0]   t;
    logic [Q3_W-1:0] pn;
    logic            b;
    for (int k = 0; k < Q3_W; k++) begin
      if (k == 0) begin
        pr = '0; pn = {height_q, 16'd0}; pd = den3_6_q;
      end else begin
        pr = r3_q[k-1]; pn = n3_q[k-1]; pd = e3_q[k-1];
      end
      t = {pr, pn[Q3_W-1]};
      b = (t >= {1'b0, pd});
      if (b) t = t - {1'b0, pd};
      r3_d[k] = t[D3_W-1:0];
      n3_d[k] = {pn[Q3_W-2:0], b};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Q3_W; k++) sside_q[k] <= '0;
    end else begin
      sside_q[0] <= sz6_q;
      for (int k = 1; k < Q3_W; k++) sside_q[k] <= sside_q[k-1];
    end
  end
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Q3_W; k++) begin
      r3_q[k] <= r3_d[k];
      n3_q[k] <= n3_d[k];
      if (k == 0) begin
        e3_q[k]             <= den3_6_q;
      end else begin
        e3_q[k]             <= e3_q[k-1];
      end
    end
  end

  // ---------------- stage 7: size saturation, zero-depth override
  size_side_t        s7in;
  logic [Q3_W-1:0]   q3;
  logic              v7_q, dz7_q;
  logic [1:0]        status7_q;
  logic [DEPTH_W-1:0] depth7_q;
  logic signed [COL_W-1:0] center7_q;
  logic [SIZE_W-1:0] size7_q;

  assign s7in = sside_q[Q3_W-1];
  assign q3   = n3_q[Q3_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else         v7_q <= s7in.v;
  end
  always_ff @(posedge clk_i) begin
    dz7_q    <= s7in.dz;
    depth7_q <= s7in.depth;
    if (s7in.dzero) begin
      // zero depth: centered sprite at full size
      status7_q <= STATUS_DEPTH_ZERO;
      center7_q <= $signed(COL_W'(half_w));
      size7_q   <= 16'hFFFF;
    end else begin
      status7_q <= STATUS_OK;
      center7_q <= s7in.center;
      size7_q   <= (q3 > Q3_W'(65535)) ? 16'hFFFF : q3[SIZE_W-1:0];
    end
  end

  // ---------------- stage 8: draw bounds, clamp, result register
  logic signed [BND_W-1:0] hs, hh, cc, wext, hext;
  logic signed [BND_W-1:0] sr, er, sc, ec;

  assign hs   = $signed(BND_W'(size7_q[SIZE_W-1:1]));
  assign hh   = $signed(BND_W'(half_h));
  assign cc   = BND_W'(center7_q);
  assign wext = $signed(BND_W'(width_q));
  assign hext = $signed(BND_W'(height_q));

  always_comb begin
    sr = hh - hs;
    if (sr < 0) sr = '0;
    er = hh + hs;
    if (er >= hext) er = hext - $signed(BND_W'(1));
    sc = cc - hs;
    if (sc < 0) sc = '0;
    ec = cc + hs;
    if (ec >= wext) ec = wext - $signed(BND_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    if (dz7_q) begin
      // singular camera: everything but the status is zero
      status_o        <= STATUS_SINGULAR;
      depth_o         <= '0;
      center_column_o <= '0;
      sprite_size_o   <= '0;
      start_column_o  <= '0;
      end_column_o    <= '0;
      start_row_o     <= '0;
      end_row_o       <= '0;
    end else begin
      status_o        <= status7_q;
      depth_o         <= $signed(depth7_q);
      center_column_o <= center7_q;
      sprite_size_o   <= size7_q;
      start_column_o  <= sc[14:0];
      end_column_o    <= ec[COL_W-1:0];
      start_row_o     <= sr[14:0];
      end_row_o       <= er[COL_W-1:0];
    end
  end

`ifndef SYNTH
  // every request produces its result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("result strobe missing after request");

  // singular camera clears the size and depth fields
  a_singular: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_SINGULAR) |-> (sprite_size_o == '0 && depth_o == '0))
    else $error("singular result carries data");

  // zero depth means full size
  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_DEPTH_ZERO) |-> (sprite_size_o == 16'hFFFF && depth_o == '0))
    else $error("zero-depth result not saturated");
`endif

endmodule
